// ===== rtl/core/wfes_pkg.sv =====
// Shared types and constants for the weighted fair egress shaper.
package wfes_pkg;

    // Field widths
    localparam int RATE_W  = 40;
    localparam int WGT_W   = 16;
    localparam int BYTES_W = 32;
    localparam int TIME_W  = 64;
    localparam int SLOT_W  = 6;

    // Divider widths: dividend is a full time word, divisor a rate word
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 40;
    localparam int DIV_CNT_W = 7;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_RATE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_WEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_WEIGHT     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WEIGHT     = 2'd3;

    // One table entry, held by one cell of the ring
    typedef struct packed {
        logic [TIME_W-1:0] free_time;
        logic [WGT_W-1:0]  weight;
    } t_entry;

endpackage

// ===== rtl/core/weighted_fair_egress_shaper_core.sv =====
// Top level of the weighted fair egress shaper: ring of slot cells, divider, control.
// For a request with bytes and identity, the ring sweeps over all slots, then the shared
// divider runs the weight-share division (skipped for a zero weight) and the service-time division.
// A new request is taken only while the sequencer is idle and the output register is free.
// Requests with no identity or zero bytes post a zero result in the cycle after accept.
// Reset (synchronous, active low) clears all slots and loads register defaults.
module weighted_fair_egress_shaper_core #(
    parameter int TABLE_ENTRIES       = 64,
    parameter int TICKS_PER_SECOND    = 1000000000,
    parameter int MAX_SERVICE_SECONDS = 1048576
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot[5:0], share_weight[21:6], byte_count[53:22], time_now[117:54], zero fill
    input  logic [119:0]                     s_axis_tdata,
    // slot_present[0], weight_finite[1]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // wait_ticks[63:0]
    output logic [63:0]                      m_axis_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [wfes_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [wfes_pkg::RATE_W-1:0]      i_cfg_wdata
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int SW = wfes_pkg::WGT_W + IW;
    localparam int SLOTS = 2 ** wfes_pkg::SLOT_W;
    localparam logic [63:0] CAP = 64'(MAX_SERVICE_SECONDS) * 64'(TICKS_PER_SECOND);
    localparam logic [29:0] TPS = 30'(TICKS_PER_SECOND);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SWEEP, ST_MUL1, ST_DIV1, ST_MUL2, ST_DIV2, ST_FIN
    } t_state;

    t_state r_state;

    logic [wfes_pkg::RATE_W-1:0]  r_total_rate;
    logic [wfes_pkg::WGT_W-1:0]   r_default_weight;
    logic [wfes_pkg::WGT_W-1:0]   r_min_weight;
    logic [wfes_pkg::WGT_W-1:0]   r_max_weight;

    logic [IW-1:0]                r_idx;
    logic [IW-1:0]                r_cnt;
    logic [wfes_pkg::WGT_W-1:0]   r_w;
    logic [wfes_pkg::BYTES_W-1:0] r_bytes;
    logic [wfes_pkg::TIME_W-1:0]  r_now;
    logic [wfes_pkg::TIME_W-1:0]  r_own_ft;
    logic [SW-1:0]                r_sum;
    logic [63:0]                  r_prod;
    logic [wfes_pkg::RATE_W-1:0]  r_rate;
    logic [63:0]                  r_ticks;
    logic                         r_div_start;
    logic                         r_load;
    wfes_pkg::t_entry             r_load_data;
    logic                         r_out_valid;
    logic [63:0]                  r_out_data;

    logic [IW-1:0]                w_mod_tab [SLOTS];
    logic [wfes_pkg::SLOT_W-1:0]  w_slot;
    logic [wfes_pkg::WGT_W-1:0]   w_weight_in;
    logic [wfes_pkg::BYTES_W-1:0] w_bytes_in;
    logic [wfes_pkg::TIME_W-1:0]  w_now_in;
    logic [wfes_pkg::WGT_W-1:0]   w_wsel;
    logic [wfes_pkg::WGT_W-1:0]   w_wlo;
    logic [wfes_pkg::WGT_W-1:0]   w_wclamp;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_div_done;
    logic [63:0]                  w_quo;
    logic [wfes_pkg::DIV_D_W-1:0] w_divisor;
    logic [63:0]                  w_start;
    logic [64:0]                  w_end;
    logic [63:0]                  w_ticks_cap;
    wfes_pkg::t_entry             w_ring [TABLE_ENTRIES];
    wfes_pkg::t_entry             w_head;

    // Unpack the request
    assign w_slot      = s_axis_tdata[5:0];
    assign w_weight_in = s_axis_tdata[21:6];
    assign w_bytes_in  = s_axis_tdata[53:22];
    assign w_now_in    = s_axis_tdata[117:54];

    // Slot wraps into the table through a constant table
    for (genvar g = 0; g < SLOTS; g++) begin : g_mod
        assign w_mod_tab[g] = IW'(g % TABLE_ENTRIES);
    end

    // Pick and clamp the weight: raise to min, then lower to max
    assign w_wsel   = s_axis_tuser[1] ? w_weight_in : r_default_weight;
    assign w_wlo    = (w_wsel < r_min_weight) ? r_min_weight : w_wsel;
    assign w_wclamp = (w_wlo > r_max_weight) ? r_max_weight : w_wlo;

    // Handshakes
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_rate     <= wfes_pkg::RATE_W'(1);
            r_default_weight <= wfes_pkg::WGT_W'(256);
            r_min_weight     <= wfes_pkg::WGT_W'(1);
            r_max_weight     <= wfes_pkg::WGT_W'(65535);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                wfes_pkg::CFG_TOTAL_RATE:     r_total_rate     <= i_cfg_wdata;
                wfes_pkg::CFG_DEFAULT_WEIGHT: r_default_weight <= i_cfg_wdata[15:0];
                wfes_pkg::CFG_MIN_WEIGHT:     r_min_weight     <= i_cfg_wdata[15:0];
                wfes_pkg::CFG_MAX_WEIGHT:     r_max_weight     <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Ring of slot cells; cell 0 is the head, entries rotate toward it
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        wfes_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (r_state == ST_SWEEP),
            .i_load      (r_load && (r_idx == IW'(g))),
            .i_load_data (r_load_data),
            .i_next      (w_ring[(g + 1) % TABLE_ENTRIES]),
            .o_entry     (w_ring[g])
        );
    end
    assign w_head = w_ring[0];

    // Shared divider: weight share first, service time second
    assign w_divisor = (r_state == ST_DIV1) ? wfes_pkg::DIV_D_W'(r_sum) : r_rate;

    wfes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Cap the service ticks; the floor of one is applied when they are registered
    assign w_ticks_cap = (w_quo > CAP) ? CAP : w_quo;

    // Start time and saturating new free time
    assign w_start = (r_own_ft > r_now) ? r_own_ft : r_now;
    assign w_end   = {1'b0, w_start} + {1'b0, r_ticks};

    // Sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_load      <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (!s_axis_tuser[0] || (w_bytes_in == '0)) begin
                            r_out_data  <= '0;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_idx   <= w_mod_tab[w_slot];
                            r_w     <= w_wclamp;
                            r_bytes <= w_bytes_in;
                            r_now   <= w_now_in;
                            r_sum   <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    // Sum weights of other busy slots, grab own free time
                    if (r_cnt == r_idx) begin
                        r_own_ft <= w_head.free_time;
                    end else if (w_head.free_time > r_now) begin
                        r_sum <= r_sum + SW'(w_head.weight);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(TABLE_ENTRIES - 1)) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_prod <= 64'(r_total_rate * r_w);
                    r_sum  <= r_sum + SW'(r_w);
                    if (r_w == '0) begin
                        r_rate  <= wfes_pkg::RATE_W'(1);
                        r_state <= ST_MUL2;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (w_div_done) begin
                        if (w_quo == '0) begin
                            r_rate <= wfes_pkg::RATE_W'(1);
                        end else begin
                            r_rate <= w_quo[wfes_pkg::RATE_W-1:0];
                        end
                        r_state <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    r_prod      <= 64'(r_bytes * TPS);
                    r_div_start <= 1'b1;
                    r_state     <= ST_DIV2;
                end
                ST_DIV2: begin
                    if (w_div_done) begin
                        r_ticks <= (w_ticks_cap == '0) ? 64'd1 : w_ticks_cap;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_load                <= 1'b1;
                        r_load_data.weight    <= r_w;
                        r_load_data.free_time <= w_end[64] ? '1 : w_end[63:0];
                        r_out_data            <= w_start - r_now;
                        r_out_valid           <= 1'b1;
                        r_state               <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV1 || r_state == ST_DIV2))
        else $error("divider finished outside a divide state");

    // A full sweep leads straight to the first multiply
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && r_cnt == IW'(TABLE_ENTRIES - 1)) |=> r_state == ST_MUL1)
        else $error("sweep did not end after one full turn");

    // The fair rate is never zero when service time is computed
    a_rate_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL2) |-> (r_rate != '0))
        else $error("fair rate is zero");

    // A slot update is written only together with a new result
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |-> r_out_valid)
        else $error("slot written without a result");

endmodule

// ===== rtl/core/wfes_cell.sv =====
// One ring cell: holds one slot's free time and weight.
module wfes_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_load,
    input  wfes_pkg::t_entry i_load_data,
    input  wfes_pkg::t_entry i_next,
    output wfes_pkg::t_entry o_entry
);

    wfes_pkg::t_entry r_entry;

    // Load an update, or take the neighbor's entry while the ring turns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/wfes_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wfes_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wfes_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [wfes_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [wfes_pkg::DIV_N_W-1:0]   o_quotient
);

    logic [wfes_pkg::DIV_D_W-1:0]   r_rem;
    logic [wfes_pkg::DIV_D_W-1:0]   r_div;
    logic [wfes_pkg::DIV_N_W-1:0]   r_quo;
    logic [wfes_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [wfes_pkg::DIV_D_W:0]     w_trial;
    logic                           w_ge;

    // Shift in the next dividend bit and test against the divisor
    assign w_trial = {r_rem, r_quo[wfes_pkg::DIV_N_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= wfes_pkg::DIV_CNT_W'(wfes_pkg::DIV_N_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wfes_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_rem <= wfes_pkg::DIV_D_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[wfes_pkg::DIV_D_W-1:0];
            end
            r_quo <= {r_quo[wfes_pkg::DIV_N_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sim/tb_weighted_fair_egress_shaper_core.sv =====
// Self-checking testbench for the weighted fair egress shaper core.
`timescale 1ns / 1ps

module tb_weighted_fair_egress_shaper_core;

    localparam int SLOTS = 64;
    localparam logic [63:0] TICKS_PER_SEC = 64'd1000000000;
    localparam logic [63:0] SERVICE_CAP = 64'd1048576 * 64'd1000000000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // slot[5:0], share_weight[21:6], byte_count[53:22], time_now[117:54], zero fill
    logic [119:0]                    s_axis_tdata;
    // slot_present[0], weight_finite[1]
    logic [1:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // wait_ticks[63:0]
    logic [63:0]                     m_axis_tdata;
    logic                            i_cfg_wr_en;
    logic [wfes_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [wfes_pkg::RATE_W-1:0]     i_cfg_wdata;

    weighted_fair_egress_shaper_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    // Shadow of the block: registers and slot table
    logic [wfes_pkg::RATE_W-1:0] sh_total_rate;
    logic [wfes_pkg::WGT_W-1:0]  sh_default_wgt, sh_min_wgt, sh_max_wgt;
    logic [63:0]                 sh_free_time [SLOTS];
    logic [wfes_pkg::WGT_W-1:0]  sh_weight [SLOTS];

    logic [63:0] wait_q[$];
    int          mismatches;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold;
    logic [63:0] sim_now;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Compute the wait for one request and advance the shadow table
    function automatic logic [63:0] predict_wait(logic [5:0] slot, logic present,
            logic [15:0] wgt_in, logic finite, logic [31:0] nbytes, logic [63:0] now);
        logic [63:0]  w;
        logic [63:0]  active;
        logic [63:0]  rate;
        logic [63:0]  ticks;
        logic [63:0]  start;
        logic [127:0] prod;
        if (!present || nbytes == 0) return 64'd0;
        w = finite ? {48'd0, wgt_in} : {48'd0, sh_default_wgt};
        if (w < {48'd0, sh_min_wgt}) w = {48'd0, sh_min_wgt};
        if (w > {48'd0, sh_max_wgt}) w = {48'd0, sh_max_wgt};
        sh_weight[slot] = w[15:0];
        active = w;
        for (int i = 0; i < SLOTS; i++)
            if (i != slot && sh_free_time[i] > now) active += {48'd0, sh_weight[i]};
        if (w == 0 || active == 0) rate = 64'd1;
        else begin
            prod = {88'd0, sh_total_rate} * {64'd0, w};
            rate = 64'(prod / {64'd0, active});
        end
        if (rate < 1) rate = 64'd1;
        ticks = ({32'd0, nbytes} * TICKS_PER_SEC) / rate;
        if (ticks > SERVICE_CAP) ticks = SERVICE_CAP;
        if (ticks == 0) ticks = 64'd1;
        start = (sh_free_time[slot] > now) ? sh_free_time[slot] : now;
        if (start > ~64'd0 - ticks) sh_free_time[slot] = ~64'd0;
        else sh_free_time[slot] = start + ticks;
        return start - now;
    endfunction

    // Offer one request, hold until accepted, then maybe idle
    task automatic send_request(logic [5:0] slot, logic present, logic [15:0] wgt,
            logic finite, logic [31:0] nbytes, logic [63:0] now);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'd0, now, nbytes, wgt, slot};
        s_axis_tuser  <= {finite, present};
        do @(posedge i_clk); while (!s_axis_tready);
        wait_q.push_back(predict_wait(slot, present, wgt, finite, nbytes, now));
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and drain every outstanding request
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (wait_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [wfes_pkg::CFG_ADDR_W-1:0] addr,
            logic [wfes_pkg::RATE_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (addr)
            wfes_pkg::CFG_TOTAL_RATE:     sh_total_rate  = data;
            wfes_pkg::CFG_DEFAULT_WEIGHT: sh_default_wgt = data[wfes_pkg::WGT_W-1:0];
            wfes_pkg::CFG_MIN_WEIGHT:     sh_min_wgt     = data[wfes_pkg::WGT_W-1:0];
            default:                      sh_max_wgt     = data[wfes_pkg::WGT_W-1:0];
        endcase
    endtask

    task automatic cfg_all(logic [39:0] rate, logic [15:0] dflt, logic [15:0] lo,
            logic [15:0] hi);
        cfg_write(wfes_pkg::CFG_TOTAL_RATE, rate);
        cfg_write(wfes_pkg::CFG_DEFAULT_WEIGHT, {24'd0, dflt});
        cfg_write(wfes_pkg::CFG_MIN_WEIGHT, {24'd0, lo});
        cfg_write(wfes_pkg::CFG_MAX_WEIGHT, {24'd0, hi});
        @(posedge i_clk);
    endtask

    // Field extremes, empty identity, zero bytes, default weight, saturation
    task automatic test_directed();
        cfg_all(40'd1000000000, 16'd512, 16'd1, 16'hFFFF);
        send_request(6'd0, 1'b0, 16'hFFFF, 1'b1, 32'hFFFFFFFF, ~64'd0);
        send_request(6'd63, 1'b1, 16'hFFFF, 1'b1, 32'd0, 64'd100);
        send_request(6'd1, 1'b1, 16'd256, 1'b1, 32'd1500, 64'd1000);
        send_request(6'd1, 1'b1, 16'd256, 1'b1, 32'd1500, 64'd1001);
        send_request(6'd2, 1'b1, 16'd0, 1'b1, 32'd1, 64'd1002);
        send_request(6'd3, 1'b1, 16'hFFFF, 1'b1, 32'd64000, 64'd1003);
        send_request(6'd4, 1'b1, 16'h1234, 1'b0, 32'd9000, 64'd1004);
        send_request(6'd2, 1'b1, 16'h00FF, 1'b1, 32'd700, 64'd1005);
        send_request(6'd63, 1'b1, 16'h8000, 1'b1, 32'hFFFFFFFF, 64'd1006);
        send_request(6'd62, 1'b1, 16'h0001, 1'b1, 32'hFFFFFFFF, ~64'd0 - 64'd5);
        send_request(6'd62, 1'b1, 16'h0001, 1'b1, 32'hFFFFFFFF, ~64'd0 - 64'd4);
        send_request(6'd61, 1'b1, 16'h5555, 1'b1, 32'h55555555, 64'h5555555555555555);
        send_request(6'd42, 1'b1, 16'hAAAA, 1'b0, 32'hAAAAAAAA, 64'hAAAAAAAAAAAAAAAA);
        send_request(6'd21, 1'b0, 16'd0, 1'b0, 32'd0, 64'd0);
        drain();
    endtask

    // Register extremes: crossed clamps, zero weight, zero and full rate
    task automatic test_config_extremes();
        cfg_all(40'd1, 16'd1, 16'hFFFF, 16'd1);
        send_request(6'd5, 1'b1, 16'd300, 1'b1, 32'd10, 64'd2000);
        send_request(6'd5, 1'b1, 16'd300, 1'b0, 32'd1, 64'd2001);
        drain();
        cfg_all(40'd0, 16'd0, 16'd0, 16'd0);
        send_request(6'd6, 1'b1, 16'd300, 1'b1, 32'd10, 64'd3000);
        send_request(6'd7, 1'b1, 16'd300, 1'b0, 32'd10, 64'd3000);
        drain();
        cfg_all(40'hFF_FFFF_FFFF, 16'hFFFF, 16'd1, 16'hFFFF);
        send_request(6'd8, 1'b1, 16'hFFFF, 1'b1, 32'd1, 64'd4000);
        send_request(6'd9, 1'b1, 16'd1, 1'b0, 32'hFFFFFFFF, 64'd4000);
        send_request(6'd9, 1'b1, 16'd1, 1'b1, 32'd1500, 64'd4001);
        drain();
    endtask

    // Mostly a moving clock with overlapping slots; a few wild requests
    task automatic test_random(int count, int tx_pct, int rx_pct);
        logic [5:0]  slot;
        logic [15:0] wgt;
        logic [31:0] nbytes;
        logic [63:0] now;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            sim_now += $urandom_range(0, 3000);
            slot   = $urandom_range(0, 15) == 0 ? 6'($urandom) : 6'($urandom_range(0, 11));
            wgt    = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 1024));
            nbytes = $urandom_range(0, 9) == 0 ? 32'($urandom) : 32'($urandom_range(1, 2000));
            now    = sim_now;
            if ($urandom_range(0, 39) == 0) now = {32'($urandom), 32'($urandom)};
            send_request(slot, $urandom_range(0, 19) != 0, wgt,
                         $urandom_range(0, 9) != 0, nbytes, now);
        end
        drain();
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_hold = 800;
        for (int n = 0; n < 12; n++) begin
            sim_now += 100;
            send_request(6'(n), 1'b1, 16'd256, 1'b1, 32'd1000, sim_now);
        end
        drain();
    endtask

    // Output side: random stall, plus a counted hold-off
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (wait_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result wait_ticks=%h", m_axis_tdata);
            end else begin
                if (m_axis_tdata !== wait_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("wait_ticks mismatch: expected %h actual %h",
                                 wait_q[0], m_axis_tdata);
                end
                void'(wait_q.pop_front());
            end
        end
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        mismatches    = 0;
        tx_idle_pct   = 29;
        rx_idle_pct   = 62;
        rx_hold       = 0;
        sim_now       = 64'd10000;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = wfes_pkg::CFG_TOTAL_RATE;
        i_cfg_wdata   = '0;
        sh_total_rate  = 40'd1;
        sh_default_wgt = 16'd256;
        sh_min_wgt     = 16'd1;
        sh_max_wgt     = 16'hFFFF;
        for (int i = 0; i < SLOTS; i++) begin
            sh_free_time[i] = '0;
            sh_weight[i]    = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        cfg_all(40'd1000000000, 16'd256, 16'd16, 16'd4096);
        test_random(350, 29, 62);
        test_backpressure();
        cfg_all(40'd250000000, 16'd100, 16'd200, 16'd100);
        test_random(350, 62, 29);
        cfg_all(40'd4000000000, 16'd1024, 16'd1, 16'hFFFF);
        test_random(350, 0, 0);

        repeat (250) @(posedge i_clk);
        if (mismatches == 0 && wait_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== weighted_fair_egress_shaper_core.f =====
rtl/core/wfes_pkg.sv
rtl/core/wfes_cell.sv
rtl/core/wfes_div.sv
rtl/core/weighted_fair_egress_shaper_core.sv
sim/tb_weighted_fair_egress_shaper_core.sv
